/* rtl/ifc_pkg.sv */
package ifc_pkg;

   // raw event types and codes
   localparam logic [15:0] EV_SYN            = 16'h0000;
   localparam logic [15:0] EV_KEY            = 16'h0001;
   localparam logic [15:0] EV_REL            = 16'h0002;
   localparam logic [15:0] EV_ABS            = 16'h0003;
   localparam logic [15:0] REPORT_CODE       = 16'h0000;
   localparam logic [15:0] MOUSE_BTN_CODE    = 16'h0110;
   localparam logic [15:0] TOUCH_BTN_CODE    = 16'h014A;
   localparam logic [15:0] ABS_X_CODE        = 16'h0000;
   localparam logic [15:0] ABS_Y_CODE        = 16'h0001;
   localparam logic [15:0] MT_X_CODE         = 16'h0035;
   localparam logic [15:0] MT_Y_CODE         = 16'h0036;
   localparam logic [15:0] REL_X_CODE        = 16'h0000;
   localparam logic [15:0] REL_Y_CODE        = 16'h0001;
   localparam logic [15:0] WHEEL_CODE        = 16'h0008;

   // result kinds, also the bit positions in a command mask
   localparam int KIND_COUNT = 6;
   localparam logic [2:0] KIND_PRESS   = 3'd0;
   localparam logic [2:0] KIND_RELEASE = 3'd1;
   localparam logic [2:0] KIND_ABS     = 3'd2;
   localparam logic [2:0] KIND_REL     = 3'd3;
   localparam logic [2:0] KIND_WHEEL   = 3'd4;
   localparam logic [2:0] KIND_KEY     = 3'd5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_REG_RELEASE_IGNORES_MOVE = 1'b0;  // paddr[2] of register 0

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [15:0]        event_type;
      logic [15:0]        event_code;
      logic signed [31:0] event_value;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         result_kind;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic [15:0]        key_code;
      logic               key_pressed;
      logic               last;
   } rsp_payload_type;

   // one queued command: the results of one input event
   typedef struct packed {
      logic [KIND_COUNT-1:0] mask;
      logic [31:0]           x;
      logic [31:0]           y;
      logic [31:0]           wheel;
      logic [15:0]           key_code;
      logic                  key_pressed;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

endpackage

/* rtl/ifc_queue.sv */
module ifc_queue #(
   parameter int DEPTH = ifc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  ifc_pkg::push_type wr,
   output logic              full,
   input  logic              pop,
   output ifc_pkg::cmd_type  head,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ifc_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = wr.push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr.cmd;
      end
   end

endmodule

/* rtl/ifc_front.sv */
module ifc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  ifc_pkg::req_payload_type event_in,
   input  logic                     release_ignores_move,
   output ifc_pkg::push_type        wr
);

   logic        button_down_ff, button_down_in;
   logic        press_ff, press_in;
   logic        release_ff, release_in;
   logic        move_ff, move_in;
   logic [31:0] pending_x_ff, pending_x_in;
   logic [31:0] pending_y_ff, pending_y_in;
   logic [31:0] committed_x_ff, committed_x_in;
   logic [31:0] committed_y_ff, committed_y_in;
   logic [31:0] sum_dx_ff, sum_dx_in;
   logic [31:0] sum_dy_ff, sum_dy_in;
   logic [31:0] sum_wheel_ff, sum_wheel_in;

   logic [15:0] ev_type, ev_code;
   logic [31:0] ev_value;
   logic        down, drop, abs_en, rel_en, wheel_en;
   logic [31:0] add_a, add_sum;

   assign ev_type  = event_in.event_type;
   assign ev_code  = event_in.event_code;
   assign ev_value = event_in.event_value;
   assign down     = (ev_value != '0);

   // frame end decisions
   assign drop     = release_ignores_move && release_ff;
   assign abs_en   = move_ff && !drop;
   assign rel_en   = !abs_en && ((sum_dx_ff != '0) || (sum_dy_ff != '0));
   assign wheel_en = (sum_wheel_ff != '0);

   // one shared adder for the relative sums
   always_comb begin
      if (ev_code == ifc_pkg::REL_X_CODE) begin
         add_a = sum_dx_ff;
      end else if (ev_code == ifc_pkg::REL_Y_CODE) begin
         add_a = sum_dy_ff;
      end else begin
         add_a = sum_wheel_ff;
      end
   end
   assign add_sum = add_a + ev_value;

   always_comb begin
      button_down_in = button_down_ff;
      press_in       = press_ff;
      release_in     = release_ff;
      move_in        = move_ff;
      pending_x_in   = pending_x_ff;
      pending_y_in   = pending_y_ff;
      committed_x_in = committed_x_ff;
      committed_y_in = committed_y_ff;
      sum_dx_in      = sum_dx_ff;
      sum_dy_in      = sum_dy_ff;
      sum_wheel_in   = sum_wheel_ff;
      wr             = '0;

      if (accept) begin
         if (ev_type == ifc_pkg::EV_SYN) begin
            if (ev_code == ifc_pkg::REPORT_CODE) begin
               wr.cmd.mask[ifc_pkg::KIND_PRESS]   = press_ff;
               wr.cmd.mask[ifc_pkg::KIND_RELEASE] = release_ff;
               wr.cmd.mask[ifc_pkg::KIND_ABS]     = abs_en;
               wr.cmd.mask[ifc_pkg::KIND_REL]     = rel_en;
               wr.cmd.mask[ifc_pkg::KIND_WHEEL]   = wheel_en;
               wr.cmd.x     = abs_en ? pending_x_ff : sum_dx_ff;
               wr.cmd.y     = abs_en ? pending_y_ff : sum_dy_ff;
               wr.cmd.wheel = sum_wheel_ff;
               wr.push = press_ff || release_ff || abs_en || rel_en || wheel_en;
               press_in   = 1'b0;
               release_in = 1'b0;
               move_in    = 1'b0;
               if (drop) begin
                  pending_x_in = committed_x_ff;
                  pending_y_in = committed_y_ff;
               end
               if (abs_en) begin
                  committed_x_in = pending_x_ff;
                  committed_y_in = pending_y_ff;
               end
               if (rel_en) begin
                  sum_dx_in = '0;
                  sum_dy_in = '0;
               end
               if (wheel_en) begin
                  sum_wheel_in = '0;
               end
            end
         end else if (ev_type == ifc_pkg::EV_KEY) begin
            if (ev_code == ifc_pkg::TOUCH_BTN_CODE || ev_code == ifc_pkg::MOUSE_BTN_CODE) begin
               if (down != button_down_ff) begin
                  button_down_in = down;
                  if (down) begin
                     press_in = 1'b1;
                  end else begin
                     release_in = 1'b1;
                  end
               end
            end else begin
               wr.push                          = 1'b1;
               wr.cmd.mask[ifc_pkg::KIND_KEY]   = 1'b1;
               wr.cmd.key_code                  = ev_code;
               wr.cmd.key_pressed               = down;
            end
         end else if (ev_type == ifc_pkg::EV_ABS) begin
            move_in = 1'b1;
            if (ev_code == ifc_pkg::ABS_X_CODE || ev_code == ifc_pkg::MT_X_CODE) begin
               pending_x_in = ev_value;
            end else if (ev_code == ifc_pkg::ABS_Y_CODE ||
                         ev_code == ifc_pkg::MT_Y_CODE) begin
               pending_y_in = ev_value;
            end
         end else if (ev_type == ifc_pkg::EV_REL) begin
            if (ev_code == ifc_pkg::REL_X_CODE) begin
               sum_dx_in = add_sum;
            end else if (ev_code == ifc_pkg::REL_Y_CODE) begin
               sum_dy_in = add_sum;
            end else if (ev_code == ifc_pkg::WHEEL_CODE) begin
               sum_wheel_in = add_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_down_ff <= 1'b0;
         press_ff       <= 1'b0;
         release_ff     <= 1'b0;
         move_ff        <= 1'b0;
         pending_x_ff   <= '0;
         pending_y_ff   <= '0;
         committed_x_ff <= '0;
         committed_y_ff <= '0;
         sum_dx_ff      <= '0;
         sum_dy_ff      <= '0;
         sum_wheel_ff   <= '0;
      end else begin
         button_down_ff <= button_down_in;
         press_ff       <= press_in;
         release_ff     <= release_in;
         move_ff        <= move_in;
         pending_x_ff   <= pending_x_in;
         pending_y_ff   <= pending_y_in;
         committed_x_ff <= committed_x_in;
         committed_y_ff <= committed_y_in;
         sum_dx_ff      <= sum_dx_in;
         sum_dy_ff      <= sum_dy_in;
         sum_wheel_ff   <= sum_wheel_in;
      end
   end

endmodule

/* rtl/ifc_back.sv */
module ifc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ifc_pkg::cmd_type         head,
   input  logic                     empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ifc_pkg::rsp_payload_type rsp_payload
);

   ifc_pkg::cmd_type                cur_ff;
   logic [ifc_pkg::KIND_COUNT-1:0]  mask_ff, mask_in;
   logic [ifc_pkg::KIND_COUNT-1:0]  sel, rest;
   logic                            rsp_valid_ff, rsp_valid_in;
   ifc_pkg::rsp_payload_type        rsp_ff, rsp_in;
   logic                            can_load, emit;
   logic [2:0]                      kind;

   assign can_load = !rsp_valid_ff || rsp_ready;
   assign emit     = can_load && (mask_ff != '0);
   // lowest pending result goes first
   assign sel      = mask_ff & (~mask_ff + 1'b1);
   assign rest     = mask_ff & ~sel;
   assign pop      = !empty && ((mask_ff == '0) || (emit && rest == '0));

   always_comb begin
      kind = ifc_pkg::KIND_PRESS;
      for (int i = 0; i < ifc_pkg::KIND_COUNT; i++) begin
         if (sel[i]) begin
            kind = 3'(i);
         end
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.result_kind = kind;
      rsp_in.last        = (rest == '0);
      case (kind)
         ifc_pkg::KIND_ABS, ifc_pkg::KIND_REL: begin
            rsp_in.x_value = cur_ff.x;
            rsp_in.y_value = cur_ff.y;
         end
         ifc_pkg::KIND_WHEEL: begin
            rsp_in.x_value = cur_ff.wheel;
         end
         ifc_pkg::KIND_KEY: begin
            rsp_in.key_code    = cur_ff.key_code;
            rsp_in.key_pressed = cur_ff.key_pressed;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mask_in = mask_ff;
      if (pop) begin
         mask_in = head.mask;
      end else if (emit) begin
         mask_in = rest;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/input_event_frame_coalescer.sv */
// path: event -> command queue -> result stage -> output register
// throughput: one event per cycle is accepted while the command queue has room;
//   results leave at one per cycle unless rsp_ready stalls them; a report-sync
//   emits at most 4 results and the queue absorbs the backlog
// reset: synchronous, active high; clears the frame state, the queue and the
//   output register, and sets release_ignores_move to 0
module input_event_frame_coalescer #(
   parameter int QUEUE_DEPTH = ifc_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ifc_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ifc_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ifc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ifc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ifc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic              release_ignores_move_ff, release_ignores_move_in;
   logic              hit, full, empty, pop;
   ifc_pkg::push_type wr;
   ifc_pkg::cmd_type  head;

   assign csr_pready = 1'b1;
   assign hit        = (csr_paddr[2] == ifc_pkg::CSR_REG_RELEASE_IGNORES_MOVE);
   assign csr_prdata = hit ? {{(ifc_pkg::CSR_DATA_W-1){1'b0}}, release_ignores_move_ff} : '0;

   always_comb begin
      release_ignores_move_in = release_ignores_move_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         release_ignores_move_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_ignores_move_ff <= 1'b0;
      end else begin
         release_ignores_move_ff <= release_ignores_move_in;
      end
   end

   assign req_ready = !full;

   ifc_front u_front (
      .clock                (clock),
      .reset                (reset),
      .accept               (req_valid && req_ready),
      .event_in             (req_payload),
      .release_ignores_move (release_ignores_move_ff),
      .wr                   (wr)
   );

   ifc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .full  (full),
      .pop   (pop),
      .head  (head),
      .empty (empty)
   );

   ifc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/ifc_checker.sv */
module ifc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ifc_pkg::rsp_payload_type rsp_payload
);

   // output register comes up empty
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // only defined result kinds leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.result_kind <= ifc_pkg::KIND_KEY)
      else $error("undefined result kind");

   // a key result is always the only result of its event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == ifc_pkg::KIND_KEY |-> rsp_payload.last)
      else $error("key result not marked last");

   // the result after a non-last one belongs to the same frame, so cannot be a key
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=>
         rsp_valid && rsp_payload.result_kind != ifc_pkg::KIND_KEY)
      else $error("frame interrupted");

endmodule

bind input_event_frame_coalescer ifc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import ifc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] RELEASE_IGNORES_MOVE_ADDR = '0;
   localparam int IDLE_MAX      = 18;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PHASE_EVENTS  = 25;

   typedef struct packed {
      bit              is_cfg;
      bit              cfg_val;
      req_payload_type ev;
      bit              fixed;
      bit              fixed_has_rsp;
      rsp_payload_type fixed_rsp;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // frame state mirrored on the testbench side
   logic        drop_move_on_release = 1'b0;
   logic        btn_down = 1'b0;
   logic        press_flag = 1'b0;
   logic        release_flag = 1'b0;
   logic        move_flag = 1'b0;
   logic [31:0] pos_x = '0;
   logic [31:0] pos_y = '0;
   logic [31:0] shown_x = '0;
   logic [31:0] shown_y = '0;
   logic [31:0] acc_dx = '0;
   logic [31:0] acc_dy = '0;
   logic [31:0] acc_wheel = '0;

   rsp_payload_type frame_out[$];
   rsp_payload_type due_results[$];
   stim_row_type    directed_rows[$];
   int              fail_count = 0;
   bit              send_burst = 1'b0;
   bit              recv_burst = 1'b0;

   input_event_frame_coalescer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_payload_type make_rsp(logic [2:0] kind, logic [31:0] x,
                                                logic [31:0] y, logic [15:0] code,
                                                logic pressed);
      rsp_payload_type r;
      r.result_kind = kind;
      r.x_value     = x;
      r.y_value     = y;
      r.key_code    = code;
      r.key_pressed = pressed;
      r.last        = 1'b0;
      return r;
   endfunction

   // advances the mirrored frame state by one event, results land in frame_out
   function automatic void coalesce_event(req_payload_type ev);
      logic            had_press;
      logic            had_release;
      logic            down;
      rsp_payload_type tail;
      frame_out.delete();
      down = (ev.event_value != 0);
      case (ev.event_type)
         EV_SYN: begin
            if (ev.event_code == REPORT_CODE) begin
               had_press    = press_flag;
               had_release  = release_flag;
               press_flag   = 1'b0;
               release_flag = 1'b0;
               if (had_press)
                  frame_out.push_back(make_rsp(KIND_PRESS, '0, '0, '0, 1'b0));
               if (had_release)
                  frame_out.push_back(make_rsp(KIND_RELEASE, '0, '0, '0, 1'b0));
               if (drop_move_on_release && had_release) begin
                  move_flag = 1'b0;
                  pos_x     = shown_x;
                  pos_y     = shown_y;
               end
               if (move_flag) begin
                  move_flag = 1'b0;
                  shown_x   = pos_x;
                  shown_y   = pos_y;
                  frame_out.push_back(make_rsp(KIND_ABS, shown_x, shown_y, '0, 1'b0));
               end else if (acc_dx != 0 || acc_dy != 0) begin
                  frame_out.push_back(make_rsp(KIND_REL, acc_dx, acc_dy, '0, 1'b0));
                  acc_dx = '0;
                  acc_dy = '0;
               end
               if (acc_wheel != 0) begin
                  frame_out.push_back(make_rsp(KIND_WHEEL, acc_wheel, '0, '0, 1'b0));
                  acc_wheel = '0;
               end
            end
         end
         EV_KEY: begin
            if (ev.event_code == TOUCH_BTN_CODE || ev.event_code == MOUSE_BTN_CODE) begin
               if (down != btn_down) begin
                  btn_down = down;
                  if (down)
                     press_flag = 1'b1;
                  else
                     release_flag = 1'b1;
               end
            end else begin
               frame_out.push_back(make_rsp(KIND_KEY, '0, '0, ev.event_code, down));
            end
         end
         EV_ABS: begin
            move_flag = 1'b1;
            if (ev.event_code == ABS_X_CODE || ev.event_code == MT_X_CODE)
               pos_x = ev.event_value;
            else if (ev.event_code == ABS_Y_CODE || ev.event_code == MT_Y_CODE)
               pos_y = ev.event_value;
         end
         EV_REL: begin
            if (ev.event_code == REL_X_CODE)
               acc_dx = acc_dx + ev.event_value;
            else if (ev.event_code == REL_Y_CODE)
               acc_dy = acc_dy + ev.event_value;
            else if (ev.event_code == WHEEL_CODE)
               acc_wheel = acc_wheel + ev.event_value;
         end
         default: ;
      endcase
      if (frame_out.size() > 0) begin
         tail = frame_out.pop_back();
         tail.last = 1'b1;
         frame_out.push_back(tail);
      end
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'($urandom_range(0, 8)) - 32'd4;
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type row_event(logic [15:0] t, logic [15:0] c, logic [31:0] v);
      stim_row_type r;
      r = '0;
      r.ev.event_type  = t;
      r.ev.event_code  = c;
      r.ev.event_value = v;
      return r;
   endfunction

   // row whose outcome is typed in: nothing, or one result that is also the last
   function automatic stim_row_type row_fixed(logic [15:0] t, logic [15:0] c, logic [31:0] v,
                                              bit has_rsp, logic [2:0] kind,
                                              logic [15:0] code, logic pressed);
      stim_row_type r;
      r = row_event(t, c, v);
      r.fixed         = 1'b1;
      r.fixed_has_rsp = has_rsp;
      r.fixed_rsp     = make_rsp(kind, '0, '0, code, pressed);
      r.fixed_rsp.last = 1'b1;
      return r;
   endfunction

   function automatic stim_row_type row_cfg(bit v);
      stim_row_type r;
      r = '0;
      r.is_cfg  = 1'b1;
      r.cfg_val = v;
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_event(req_payload_type ev, bit fixed, bit has_rsp,
                             rsp_payload_type fixed_rsp);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      coalesce_event(ev);
      if (fixed) begin
         if (has_rsp)
            due_results.push_back(fixed_rsp);
      end else begin
         foreach (frame_out[i]) due_results.push_back(frame_out[i]);
      end
      @(negedge clock);
   endtask

   // only while the block is idle: all results in and the pipeline settled
   task automatic set_release_mode(bit v);
      logic [CSR_DATA_W-1:0] wdata;
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      wdata    = $urandom;
      wdata[0] = v;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RELEASE_IGNORES_MOVE_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      drop_move_on_release = v;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(v)) begin
         $display("%0t: register readback mismatch: expected %0h actual %0h",
                  $time, CSR_DATA_W'(v), csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stalls, each transaction checked against the oldest expectation
   initial begin
      int              stall;
      rsp_payload_type exp_rsp;
      rsp_payload_type got;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = recv_burst ? 0 : $urandom_range(0, IDLE_MAX);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = rsp_payload;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result: kind %0d x %0h y %0h code %0h pressed %b last %b",
                     $time, got.result_kind, got.x_value, got.y_value, got.key_code,
                     got.key_pressed, got.last);
            fail_count++;
         end else begin
            exp_rsp = due_results.pop_front();
            if (got.result_kind !== exp_rsp.result_kind || got.x_value !== exp_rsp.x_value ||
                got.y_value !== exp_rsp.y_value || got.key_code !== exp_rsp.key_code ||
                got.key_pressed !== exp_rsp.key_pressed || got.last !== exp_rsp.last) begin
               $display("%0t: result mismatch: expected kind %0d x %0h y %0h code %0h %b %b",
                        $time, exp_rsp.result_kind, exp_rsp.x_value, exp_rsp.y_value,
                        exp_rsp.key_code, exp_rsp.key_pressed, exp_rsp.last);
               $display("%0t:                  actual   kind %0d x %0h y %0h code %0h %b %b",
                        $time, got.result_kind, got.x_value, got.y_value,
                        got.key_code, got.key_pressed, got.last);
               fail_count++;
            end
         end
         if ($urandom_range(0, 15) == 0)
            recv_burst = !recv_burst;
         @(negedge clock);
      end
   end

   initial begin
      req_payload_type ev;
      int              counted;
      int              n_ev;
      int              sel;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      directed_rows.push_back(row_cfg(1'b0));
      // empty frame, unknown type and a non-report sync give nothing
      directed_rows.push_back(row_fixed(EV_SYN, REPORT_CODE, 32'h0, 1'b0, KIND_PRESS, '0, 1'b0));
      directed_rows.push_back(row_fixed(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0,
                                        KIND_PRESS, '0, 1'b0));
      directed_rows.push_back(row_fixed(EV_SYN, 16'hFFFF, 32'h0, 1'b0, KIND_PRESS, '0, 1'b0));
      // plain keys go straight out
      directed_rows.push_back(row_fixed(EV_KEY, 16'hFFFF, 32'h8000_0000, 1'b1,
                                        KIND_KEY, 16'hFFFF, 1'b1));
      directed_rows.push_back(row_fixed(EV_KEY, 16'h0000, 32'h0, 1'b1, KIND_KEY, 16'h0000, 1'b0));
      // absolute wins over relative, wheel still reported, x sum wraps
      directed_rows.push_back(row_event(EV_ABS, ABS_X_CODE, 32'h7FFF_FFFF));
      directed_rows.push_back(row_event(EV_ABS, MT_Y_CODE, 32'h8000_0000));
      directed_rows.push_back(row_event(EV_ABS, 16'h0FFF, 32'd5));
      directed_rows.push_back(row_event(EV_REL, REL_X_CODE, 32'h7FFF_FFFF));
      directed_rows.push_back(row_event(EV_REL, REL_X_CODE, 32'd1));
      directed_rows.push_back(row_event(EV_REL, WHEEL_CODE, 32'hFFFF_FFFF));
      directed_rows.push_back(row_event(EV_SYN, REPORT_CODE, 32'h0));
      directed_rows.push_back(row_event(EV_SYN, REPORT_CODE, 32'h0));
      // y sum cancels, unknown relative code ignored
      directed_rows.push_back(row_event(EV_REL, REL_Y_CODE, 32'd5));
      directed_rows.push_back(row_event(EV_REL, REL_Y_CODE, -32'sd5));
      directed_rows.push_back(row_event(EV_REL, 16'hFFFF, 32'd9));
      // press, unchanged button, release in one frame
      directed_rows.push_back(row_event(EV_KEY, TOUCH_BTN_CODE, 32'd1));
      directed_rows.push_back(row_event(EV_KEY, MOUSE_BTN_CODE, 32'd7));
      directed_rows.push_back(row_event(EV_KEY, TOUCH_BTN_CODE, 32'd0));
      directed_rows.push_back(row_event(EV_SYN, REPORT_CODE, 32'h0));
      directed_rows.push_back(row_event(EV_KEY, MOUSE_BTN_CODE, 32'd1));
      directed_rows.push_back(row_fixed(EV_SYN, REPORT_CODE, 32'h0, 1'b1, KIND_PRESS, '0, 1'b0));
      // release drops the pending position, relative motion goes out instead
      directed_rows.push_back(row_cfg(1'b1));
      directed_rows.push_back(row_event(EV_ABS, MT_X_CODE, 32'd100));
      directed_rows.push_back(row_event(EV_REL, REL_X_CODE, 32'd3));
      directed_rows.push_back(row_event(EV_KEY, TOUCH_BTN_CODE, 32'd0));
      directed_rows.push_back(row_event(EV_SYN, REPORT_CODE, 32'h0));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg)
            set_release_mode(directed_rows[i].cfg_val);
         else
            send_event(directed_rows[i].ev, directed_rows[i].fixed,
                       directed_rows[i].fixed_has_rsp, directed_rows[i].fixed_rsp);
      end

      for (int phase = 0; phase < 3; phase++) begin
         set_release_mode(phase != 1);
         counted = 0;
         while (counted < PHASE_EVENTS) begin
            n_ev = $urandom_range(1, 6);
            for (int k = 0; k < n_ev; k++) begin
               sel = $urandom_range(0, 99);
               ev.event_value = pick_value();
               if (sel < 25) begin
                  ev.event_type = EV_ABS;
                  case ($urandom_range(0, 9))
                     0, 1: ev.event_code = ABS_X_CODE;
                     2, 3: ev.event_code = ABS_Y_CODE;
                     4, 5: ev.event_code = MT_X_CODE;
                     6, 7: ev.event_code = MT_Y_CODE;
                     default: ev.event_code = 16'($urandom);
                  endcase
               end else if (sel < 50) begin
                  ev.event_type = EV_REL;
                  case ($urandom_range(0, 2))
                     0: ev.event_code = REL_X_CODE;
                     1: ev.event_code = REL_Y_CODE;
                     default: ev.event_code = WHEEL_CODE;
                  endcase
               end else if (sel < 75) begin
                  ev.event_type = EV_KEY;
                  ev.event_code = $urandom_range(0, 1) ? TOUCH_BTN_CODE : MOUSE_BTN_CODE;
                  // mostly flip the button so press and release flags get set
                  if ($urandom_range(0, 3) != 0) begin
                     if (btn_down)
                        ev.event_value = '0;
                     else if (ev.event_value == 0)
                        ev.event_value = 32'd1;
                  end
               end else if (sel < 90) begin
                  ev.event_type = EV_KEY;
                  ev.event_code = 16'($urandom);
               end else begin
                  // noise the block ignores
                  case ($urandom_range(0, 2))
                     0: begin
                        ev.event_type = 16'($urandom_range(4, 65535));
                        ev.event_code = 16'($urandom);
                     end
                     1: begin
                        ev.event_type = EV_SYN;
                        ev.event_code = 16'($urandom_range(1, 65535));
                     end
                     default: begin
                        ev.event_type = EV_REL;
                        ev.event_code = 16'($urandom_range(9, 65535));
                     end
                  endcase
                  counted--;
               end
               send_event(ev, 1'b0, 1'b0, '0);
               counted++;
            end
            // a few frames run on into the next without a report
            if ($urandom_range(0, 9) != 0) begin
               ev.event_type  = EV_SYN;
               ev.event_code  = REPORT_CODE;
               ev.event_value = $urandom;
               send_event(ev, 1'b0, 1'b0, '0);
               counted++;
            end
            if ($urandom_range(0, 7) == 0)
               send_burst = !send_burst;
         end
      end

      req_valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #1000000;
      $display("timeout with %0d results outstanding", due_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* input_event_frame_coalescer.f */
rtl/ifc_pkg.sv
rtl/ifc_queue.sv
rtl/ifc_front.sv
rtl/ifc_back.sv
rtl/input_event_frame_coalescer.sv
rtl/ifc_checker.sv
sim/tb_top.sv
